FILE: hw/rtl/u8dec_pkg.sv
package u8dec_pkg;

    localparam int unsigned RESULT_MAX = 3;   // results one byte can cause
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned RCNT_W     = $clog2(RESULT_MAX + 1);

    // Sequence lengths held in the expected-length register
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // Byte counts reported with each character
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD_END  = 8'hF0;
    localparam logic [1:0] TRAIL_TAG = 2'b10;

    typedef struct packed {
        logic [15:0] code_point;
        logic [1:0]  byte_count;
        logic        last_of_run;
    } u8dec_result_t;

    typedef struct packed {
        logic [7:0] pend0;     // buffered lead byte
        logic [7:0] pend1;     // buffered first trail byte
        logic [1:0] count;     // bytes buffered, 0..2
        logic [1:0] exp_len;   // length being collected, 0 when idle
    } u8dec_state_t;

    function automatic u8dec_result_t make_result(logic [15:0] cp, logic [1:0] cnt);
        u8dec_result_t r;
        r.code_point  = cp;
        r.byte_count  = cnt;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/utf8_to_ucs2_stream_decoder.sv
// UTF-8 to UCS-2 stream decoder.
//
// Input channel (s_axis): one word per byte of UTF-8 text. tdata carries the
// byte, tlast marks the final byte of the text; after it every byte still
// buffered comes out as itself.
// Output channel (m_axis): one word per 16-bit character, with the number of
// input bytes it consumed. tlast is high on the final word caused by one
// input byte. Runs of up to three bytes are decoded; a broken run releases
// its buffered bytes as themselves, one word each, before the breaking byte.
//
// A byte taken from s_axis is registered in the input stage, decoded there,
// and its results go into the result queue that feeds m_axis. Throughput: one
// byte per cycle with a ready receiver. The held byte advances only when the
// four-word result queue has room for three words, so a byte that yields two
// or three words can hold s_axis_tready low while the queue drains one word
// per cycle. The rate is set by the single m_axis port of the result queue.
// Reset clears the input stage, the pending-run state and the result queue.
// When the receiver stalls, results wait in the queue and input backs up
// behind it; no word is lost or repeated.
module utf8_to_ucs2_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] code_point, [17:16] byte_count, rest zero
    output logic        m_axis_tlast    // last_of_run
);
    import u8dec_pkg::*;

    // Input stage
    logic                               in_valid_reg;
    logic [7:0]                         in_byte_reg;
    logic                               in_last_reg;
    logic                               in_load;
    logic                               consume;

    // Pending-run state
    u8dec_state_t                       state_reg;
    u8dec_state_t                       state_next;

    logic [RCNT_W-1:0]                  res_count;
    u8dec_result_t [RESULT_MAX-1:0]     results;
    logic                               fifo_room;
    u8dec_result_t                      out_word;

    // Advance the held byte only when the queue can take all its results
    assign consume       = in_valid_reg && fifo_room;
    assign s_axis_tready = !in_valid_reg || consume;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;
            if (consume)
                state_reg <= state_next;
        end
    end

    // Input payload: no reset; read only while the input stage is valid
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    u8dec_decode u_decode (
        .data_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .res_count   (res_count),
        .results     (results)
    );

    u8dec_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (consume ? res_count : '0),
        .push_data  (results),
        .pop        (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_word),
        .room       (fifo_room)
    );

    assign m_axis_tdata = {6'b0, out_word.byte_count, out_word.code_point};
    assign m_axis_tlast = out_word.last_of_run;

endmodule

FILE: hw/rtl/u8dec_decode.sv
module u8dec_decode (
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_text,
    input  u8dec_pkg::u8dec_state_t           state_cur,
    output u8dec_pkg::u8dec_state_t           state_next,
    output logic [u8dec_pkg::RCNT_W-1:0]      res_count,
    output u8dec_pkg::u8dec_result_t [u8dec_pkg::RESULT_MAX-1:0] results
);
    import u8dec_pkg::*;

    logic                                  trail;
    logic                                  is_lead;
    logic [RCNT_W-1:0]                     n;
    u8dec_state_t                          st;
    u8dec_result_t [RESULT_MAX-1:0]        r;

    assign trail   = (data_byte[7:6] == TRAIL_TAG);
    assign is_lead = (data_byte >= LEAD_MIN) && (data_byte < LEAD_END);

    always_comb
    begin
        st = state_cur;
        n  = '0;
        r  = '0;

        // Trail byte continuing a pending run: complete or buffer it
        if ((st.count != 2'd0) && trail)
        begin
            if (({1'b0, st.count} + 3'd1) >= {1'b0, st.exp_len})
            begin
                if (st.exp_len == LEN_TWO)
                    r[n[1:0]] = make_result({5'b0, st.pend0[4:0], data_byte[5:0]}, CNT_TWO);
                else
                    r[n[1:0]] = make_result({st.pend0[3:0], st.pend1[5:0], data_byte[5:0]},
                                            CNT_THREE);
                n          = n + 1'b1;
                st.count   = 2'd0;
                st.exp_len = LEN_NONE;
            end
            else
            begin
                st.pend1 = data_byte;
                st.count = 2'd2;
            end
        end
        else
        begin
            // Broken run: drop buffered bytes out as themselves
            if (st.count >= 2'd1)
            begin
                r[n[1:0]] = make_result({8'h00, st.pend0}, CNT_ONE);
                n         = n + 1'b1;
            end
            if (st.count >= 2'd2)
            begin
                r[n[1:0]] = make_result({8'h00, st.pend1}, CNT_ONE);
                n         = n + 1'b1;
            end
            st.count   = 2'd0;
            st.exp_len = LEN_NONE;

            // Handle the byte afresh
            if (is_lead)
            begin
                st.pend0   = data_byte;
                st.count   = 2'd1;
                st.exp_len = (data_byte < LEAD3_MIN) ? LEN_TWO : LEN_THREE;
            end
            else
            begin
                r[n[1:0]] = make_result({8'h00, data_byte}, CNT_ONE);
                n         = n + 1'b1;
            end
        end

        // End of text: flush whatever is still buffered
        if (end_of_text)
        begin
            if (st.count >= 2'd1)
            begin
                r[n[1:0]] = make_result({8'h00, st.pend0}, CNT_ONE);
                n         = n + 1'b1;
            end
            if (st.count >= 2'd2)
            begin
                r[n[1:0]] = make_result({8'h00, st.pend1}, CNT_ONE);
                n         = n + 1'b1;
            end
            st.count   = 2'd0;
            st.exp_len = LEN_NONE;
        end

        if (n != '0)
            r[n[1:0] - 2'd1].last_of_run = 1'b1;
    end

    assign state_next = st;
    assign res_count  = n;
    assign results    = r;

endmodule

FILE: hw/rtl/u8dec_fifo.sv
module u8dec_fifo (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [u8dec_pkg::RCNT_W-1:0]           push_count,
    input  u8dec_pkg::u8dec_result_t [u8dec_pkg::RESULT_MAX-1:0] push_data,
    input  logic                                   pop,
    output logic                                   out_valid,
    output u8dec_pkg::u8dec_result_t               out_data,
    output logic                                   room
);
    import u8dec_pkg::*;

    u8dec_result_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg;
    logic [PTR_W-1:0]          wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [PTR_W-1:0]          rd_ptr_next;
    logic [FCNT_W-1:0]         count_reg;
    logic [FCNT_W-1:0]         count_next;
    logic                      do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    // Room for a full burst of results once this cycle's pop is counted
    assign room = (FCNT_W'(FIFO_DEPTH) - count_reg + FCNT_W'(do_pop)) >= FCNT_W'(RESULT_MAX);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
    assign count_next  = count_reg + FCNT_W'(push_count) - FCNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RESULT_MAX; k++)
        begin
            if (RCNT_W'(k) < push_count)
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
        end
    end

endmodule
